>>> hw/rtl/isort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_pkg
// shared beat types and status codes for the insertion sorter
// ----------------------------------------------------------------------------
package isort_pkg;

	localparam int unsigned VALUE_W  = 31;
	localparam int unsigned STATUS_W = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_TAKE   = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef logic [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic   cmd;
		value_t value;
	} item_t;

	typedef struct packed {
		value_t              result_value;
		logic [STATUS_W-1:0] status;
		logic                store_emptied;
	} result_t;

	// per-cycle operation broadcast along the cell row
	typedef struct packed {
		logic ins_en;
		logic take_en;
	} cell_op_t;

endpackage

>>> hw/rtl/insertion_sorter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_core
// sorted store on a row of CAPACITY cells; insert places a value, take pops the smallest
// ----------------------------------------------------------------------------
// timing: the result beat is registered and appears in the cycle after its item beat is accepted
// throughput: one item per cycle, busy stays low; each cell compares once per insert
// reset: arst_n clears the fill count and the result strobe, cell contents stay undefined
// the receiver cannot stall, so each result beat is shown for exactly one cycle
module insertion_sorter_core import isort_pkg::*; #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	result_t          result_q;

	logic     accept;
	logic     is_full;
	logic     is_empty;
	cell_op_t op;

	value_t   cell_value [CAPACITY];
	logic     cell_gt    [CAPACITY];

	// every item finishes in its accept cycle, nothing to hold off
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// dropped inserts and empty takes leave the row untouched
	assign op.ins_en  = accept && (item.cmd == CMD_INSERT) && !is_full;
	assign op.take_en = accept && (item.cmd == CMD_TAKE) && !is_empty;

	// cell row: the gt chain marks where the new value goes
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   occ;
		logic   lgt;
		value_t lval;
		value_t rval;

		assign occ = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign lgt  = 1'b0;
			assign lval = item.value;
		end else begin : g_body
			assign lgt  = cell_gt[i-1];
			assign lval = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rval = cell_value[i];
		end else begin : g_inner
			assign rval = cell_value[i+1];
		end

		isort_cell u_cell (
			.clk        (clk),
			.op         (op),
			.occupied   (occ),
			.ins_value  (item.value),
			.left_gt    (lgt),
			.left_value (lval),
			.right_value(rval),
			.gt         (cell_gt[i]),
			.value      (cell_value[i])
		);
	end

	// fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (op.ins_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (op.take_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.result_value  <= op.take_en ? cell_value[0] : '0;
			result_q.store_emptied <= op.take_en && (count_q == CNT_W'(1));
			unique case (item.cmd)
				CMD_INSERT: result_q.status <= is_full ? STATUS_FULL : STATUS_OK;
				CMD_TAKE:   result_q.status <= is_empty ? STATUS_EMPTY : STATUS_OK;
				default:    result_q.status <= STATUS_OK;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> hw/rtl/isort_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_cell
// one slot of the sorted row: holds a value, shifts right on insert, left on take
// ----------------------------------------------------------------------------
module isort_cell import isort_pkg::*; (
	input  logic     clk,
	input  cell_op_t op,
	input  logic     occupied,
	input  value_t   ins_value,
	input  logic     left_gt,
	input  value_t   left_value,
	input  value_t   right_value,
	output logic     gt,
	output value_t   value
);

	value_t value_q;

	// empty slots behave as larger than anything
	assign gt    = !occupied || (value_q > ins_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (op.ins_en && gt) begin
			// left neighbour also moves up: take its value, else the new one lands here
			value_q <= left_gt ? left_value : ins_value;
		end else if (op.take_en) begin
			value_q <= right_value;
		end
	end

endmodule

>>> dv/insertion_sorter_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_core_checker
// watches the item and result channels of the sorter, keeps a shadow of the
// sorted store, predicts each result beat and compares it field by field
// ----------------------------------------------------------------------------
module insertion_sorter_core_checker import isort_pkg::*; #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        done,
	input  result_t     result,
	output int unsigned fail_count,
	output int unsigned outstanding
);

	value_t      sorted_shadow[$];
	result_t     awaited_results[$];
	result_t     oldest;
	int unsigned mismatches;

	// insert lands after any equal values, take pops the front
	function automatic result_t sort_step(input item_t beat);
		result_t     r;
		int unsigned pos;
		r = '0;
		r.status = STATUS_OK;
		if (beat.cmd == CMD_INSERT) begin
			if (sorted_shadow.size() >= CAPACITY) begin
				r.status = STATUS_FULL;
			end else begin
				pos = 0;
				while (pos < sorted_shadow.size() && sorted_shadow[pos] <= beat.value)
					pos++;
				sorted_shadow.insert(pos, beat.value);
			end
		end else if (sorted_shadow.size() == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			r.result_value = sorted_shadow.pop_front();
			r.store_emptied = (sorted_shadow.size() == 0);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_shadow.delete();
			awaited_results.delete();
			mismatches = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing awaited, actual %h", $time,
						result);
				end else begin
					oldest = awaited_results.pop_front();
					if (result.result_value !== oldest.result_value) begin
						mismatches++;
						$display("%0t: result_value expected %h actual %h", $time,
							oldest.result_value, result.result_value);
					end
					if (result.status !== oldest.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d", $time,
							oldest.status, result.status);
					end
					if (result.store_emptied !== oldest.store_emptied) begin
						mismatches++;
						$display("%0t: store_emptied expected %b actual %b", $time,
							oldest.store_emptied, result.store_emptied);
					end
				end
			end
			if (start && !busy)
				awaited_results.insert(awaited_results.size(), sort_step(item));
			fail_count <= mismatches;
			outstanding <= awaited_results.size();
		end
	end

endmodule

>>> dv/insertion_sorter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_core_test
// drives insert and take beats into the sorter: a directed opening on the
// empty store, extremes and duplicates, then random rounds that fill the
// store past capacity and drain it past empty under varying sender gaps
// ----------------------------------------------------------------------------
module insertion_sorter_core_test;
	import isort_pkg::*;

	localparam int unsigned CAPACITY       = 256;
	localparam int unsigned CLK_PERIOD_NS  = 20;
	localparam int unsigned RESET_CYCLES   = 3;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	// the result beat comes in the cycle after its item; the settle wait at the end catches strays
	localparam int unsigned SETTLE_CYCLES  = 4;
	// narrow value span so that duplicates are common
	localparam int unsigned DUP_SPAN       = 15;
	localparam value_t      VALUE_MAX      = '1;

	// bias of a random round: mostly inserts, mostly takes, or even
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_e;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned idle_pct;
	int unsigned quiet_cycles;

	insertion_sorter_core #(
		.CAPACITY (CAPACITY)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	insertion_sorter_core_checker #(
		.CAPACITY (CAPACITY)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD_NS / 2) clk = ~clk;
	end

	// value mix: the two extremes, a narrow span for duplicates, and the full range
	function automatic value_t pick_value();
		case ($urandom_range(9))
			0: return '0;
			1: return VALUE_MAX;
			2, 3, 4: return value_t'($urandom_range(DUP_SPAN));
			default: return value_t'($urandom);
		endcase
	endfunction

	// one item beat; random idle cycles in front of it carry junk with start low,
	// then start is held until the block takes the beat
	task automatic send_beat(input logic cmd, input value_t v);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			item = item_t'($urandom);
		end
		@(negedge clk);
		start = 1'b1;
		item.cmd = cmd;
		item.value = v;
		do @(posedge clk); while (busy);
	endtask

	// random round; the value field of a take is randomised too since it is ignored
	task automatic run_round(input mix_e mix, input int unsigned gap_pct,
			input int unsigned beats);
		int unsigned take_pct;
		idle_pct = gap_pct;
		case (mix)
			MIX_FILL: take_pct = 5;
			MIX_DRAIN: take_pct = 95;
			default: take_pct = 50;
		endcase
		repeat (beats)
			send_beat(($urandom_range(99) < take_pct) ? CMD_TAKE : CMD_INSERT, pick_value());
	endtask

	// watchdog: too long with no beat on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** insertion_sorter_core: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		idle_pct = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed opening, back to back
		// take straight after reset hits the empty store
		send_beat(CMD_TAKE, VALUE_MAX);
		// extremes, duplicates at both ends and alternating bit patterns
		send_beat(CMD_INSERT, VALUE_MAX);
		send_beat(CMD_INSERT, '0);
		send_beat(CMD_INSERT, '0);
		send_beat(CMD_INSERT, value_t'(DUP_SPAN));
		send_beat(CMD_INSERT, VALUE_MAX);
		send_beat(CMD_INSERT, value_t'(32'h5555_5555));
		send_beat(CMD_INSERT, value_t'(32'h2AAA_AAAA));
		send_beat(CMD_INSERT, value_t'(1));
		// read everything back in order; the eighth take empties the store, the one after it hits empty
		repeat (8)
			send_beat(CMD_TAKE, value_t'($urandom));
		send_beat(CMD_TAKE, '0);
		// a single held value: insert then take empties it at once
		send_beat(CMD_INSERT, value_t'(DUP_SPAN));
		send_beat(CMD_TAKE, VALUE_MAX);
		send_beat(CMD_TAKE, VALUE_MAX);

		// random rounds; fill rounds run well past capacity so that inserts get
		// dropped, drain rounds run past empty
		run_round(MIX_FILL, 0, 300);
		run_round(MIX_DRAIN, 84, 300);
		run_round(MIX_EVEN, 17, 250);
		run_round(MIX_FILL, 84, 300);
		run_round(MIX_DRAIN, 0, 300);
		run_round(MIX_EVEN, 17, 250);

		@(negedge clk);
		start = 1'b0;

		// drain: wait for the last result beat, then a little longer for strays
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("** insertion_sorter_core: PASSED **");
		else
			$display("** insertion_sorter_core: FAILED **");
		$finish;
	end

endmodule
